/* src/fbab_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fbab_pkg;

	localparam int COORD_W = 14;
	localparam int SIZE_W = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = 1;
	localparam int CMDQ_CW = 2;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_BLIT  = 2'd1,
		MODE_STAMP = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_PAINT = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LINE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COLUMN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRUSH_THICKNESS = 3'd4;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [SIZE_W-1:0]  size;
		color_t             color;
	} cmd_t;

	function automatic logic [7:0] mix8(input logic [7:0] old_c, input logic [7:0] src_c,
			input logic [7:0] a);
		logic [15:0] sum;
		logic [16:0] adj;
		sum = ({8'd0, old_c} * {8'd0, a}) + ({8'd0, src_c} * {8'd0, 8'd255 - a}) + 16'd127;
		adj = {1'b0, sum} + {9'd0, sum[15:8]} + 17'd1;
		return adj[15:8];
	endfunction

	function automatic logic [23:0] blend(input logic [23:0] px, input color_t c);
		return {mix8(px[23:16], c.red, c.alpha), mix8(px[15:8], c.green, c.alpha),
			mix8(px[7:0], c.blue, c.alpha)};
	endfunction

endpackage

`default_nettype wire

/* src/fbab_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module fbab_front
	import fbab_pkg::*;
#(
	parameter int MAX_BRUSH = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [1:0]           mode,
	input  wire  [10:0]          pos_line,
	input  wire  [10:0]          pos_column,
	input  wire  [7:0]           src_red,
	input  wire  [7:0]           src_green,
	input  wire  [7:0]           src_blue,
	input  wire  [7:0]           src_alpha,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CFG_IDX_W-1:0] cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	input  wire                  clearing,
	input  wire                  q_full,
	output logic                 push,
	output cmd_t                 push_cmd
);

	logic [11:0]       offset_line_q;
	logic [11:0]       offset_column_q;
	logic [11:0]       picture_height_q;
	logic [11:0]       picture_width_q;
	logic [SIZE_W-1:0] brush_thickness_q;

	logic [SIZE_W-1:0]  thick_sat;
	logic [COORD_W-1:0] line_ext;
	logic [COORD_W-1:0] col_ext;
	logic [COORD_W-1:0] ol_ext;
	logic [COORD_W-1:0] oc_ext;
	logic [COORD_W-1:0] half_ext;
	logic               clip_ok;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full | clearing;
	assign push      = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_line_q     <= '0;
			offset_column_q   <= '0;
			picture_height_q  <= '0;
			picture_width_q   <= '0;
			brush_thickness_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OFFSET_LINE:     offset_line_q     <= cfg_data;
				REG_OFFSET_COLUMN:   offset_column_q   <= cfg_data;
				REG_PICTURE_HEIGHT:  picture_height_q  <= cfg_data;
				REG_PICTURE_WIDTH:   picture_width_q   <= cfg_data;
				REG_BRUSH_THICKNESS: brush_thickness_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		thick_sat = (brush_thickness_q > SIZE_W'(MAX_BRUSH)) ? SIZE_W'(MAX_BRUSH)
			: brush_thickness_q;
		line_ext  = COORD_W'(pos_line);
		col_ext   = COORD_W'(pos_column);
		ol_ext    = {{(COORD_W-12){offset_line_q[11]}}, offset_line_q};
		oc_ext    = {{(COORD_W-12){offset_column_q[11]}}, offset_column_q};
		half_ext  = COORD_W'(thick_sat[SIZE_W-1:1]);
		clip_ok   = ({1'b0, pos_line} < picture_height_q) &&
			({1'b0, pos_column} < picture_width_q);

		push_cmd.color.red   = src_red;
		push_cmd.color.green = src_green;
		push_cmd.color.blue  = src_blue;
		push_cmd.color.alpha = src_alpha;

		case (mode_t'(mode))
			MODE_CLEAR: begin
				push_cmd.op   = OP_CLEAR;
				push_cmd.row  = '0;
				push_cmd.col  = '0;
				push_cmd.size = '0;
			end
			MODE_BLIT: begin
				push_cmd.op   = OP_PAINT;
				push_cmd.row  = line_ext + ol_ext;
				push_cmd.col  = col_ext + oc_ext;
				push_cmd.size = clip_ok ? SIZE_W'(1) : '0;
			end
			MODE_STAMP: begin
				push_cmd.op   = OP_PAINT;
				push_cmd.row  = line_ext + ol_ext - half_ext;
				push_cmd.col  = col_ext + oc_ext - half_ext;
				push_cmd.size = thick_sat;
			end
			MODE_READ: begin
				push_cmd.op   = OP_READ;
				push_cmd.row  = line_ext;
				push_cmd.col  = col_ext;
				push_cmd.size = SIZE_W'(1);
			end
			default: begin
				push_cmd.op   = OP_READ;
				push_cmd.row  = line_ext;
				push_cmd.col  = col_ext;
				push_cmd.size = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/fbab_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module fbab_cmd_fifo
	import fbab_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  push,
	input  cmd_t push_cmd,
	output logic full,
	input  wire  pop,
	output cmd_t head,
	output logic empty
);

	cmd_t               entries_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;

	assign full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CMDQ_CW'(1);
				2'b01:   count_q <= count_q - CMDQ_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command queue read while empty");
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rd_ptr_q)))
		else $error("pending command lost without a pop");
`endif

endmodule

`default_nettype wire

/* src/fbab_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module fbab_back
	import fbab_pkg::*;
#(
	parameter int FRAME_HEIGHT = 256,
	parameter int FRAME_WIDTH  = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_empty,
	input  cmd_t       q_head,
	output logic       pop,
	output logic       clearing,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] read_red,
	output logic [7:0] read_green,
	output logic [7:0] read_blue,
	output logic       hit
);

	localparam int PIX_N  = FRAME_HEIGHT * FRAME_WIDTH;
	localparam int ADDR_W = (PIX_N > 1) ? $clog2(PIX_N) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX_N - 1);
	localparam logic [COORD_W-1:0] FH_C = COORD_W'(FRAME_HEIGHT);
	localparam logic [COORD_W-1:0] FW_C = COORD_W'(FRAME_WIDTH);

	typedef enum logic [3:0] {
		ST_CLR  = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_RUN  = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	state_t st_q;

	cmd_t              cmd_q;
	logic [SIZE_W-1:0] j_q;
	logic [SIZE_W-1:0] k_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              hit_acc_q;

	logic [23:0] frame_mem [PIX_N];

	logic              v_s1;
	logic              wr_s1;
	logic              rd_s1;
	logic              hit_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [23:0]       rdata_s1;

	logic              fwd_v_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic [23:0]       fwd_data_q;

	logic       out_valid_q;
	logic [7:0] out_red_q;
	logic [7:0] out_green_q;
	logic [7:0] out_blue_q;
	logic       out_hit_q;

	logic [COORD_W-1:0] cell_row;
	logic [COORD_W-1:0] cell_col;
	logic               cell_in;
	logic [ADDR_W-1:0]  cell_addr;
	logic               brush_empty;
	logic               j_last;
	logic               k_last;

	logic              iss_v;
	logic [ADDR_W-1:0] iss_addr;
	logic              iss_wr;
	logic              iss_rd;
	logic              iss_hit;
	logic              iss_last;

	logic [23:0]       old_px;
	logic [23:0]       new_px;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [23:0]       mem_wdata;
	logic              done_s1;

	assign clearing  = (st_q == ST_CLR);
	assign pop       = (st_q == ST_IDLE) && !q_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign read_red   = out_red_q;
	assign read_green = out_green_q;
	assign read_blue  = out_blue_q;
	assign hit        = out_hit_q;

	always_comb begin
		cell_row    = cmd_q.row + COORD_W'(j_q);
		cell_col    = cmd_q.col + COORD_W'(k_q);
		cell_in     = !cell_row[COORD_W-1] && (cell_row < FH_C) &&
			!cell_col[COORD_W-1] && (cell_col < FW_C);
		cell_addr   = ADDR_W'(ADDR_W'(cell_row[COORD_W-2:0]) * ADDR_W'(FRAME_WIDTH) +
			ADDR_W'(cell_col[COORD_W-2:0]));
		brush_empty = (cmd_q.size == '0);
		j_last      = (j_q == cmd_q.size - SIZE_W'(1));
		k_last      = (k_q == cmd_q.size - SIZE_W'(1));

		iss_v = (st_q == ST_RUN);
		case (cmd_q.op)
			OP_CLEAR: begin
				iss_addr = sweep_q;
				iss_wr   = 1'b1;
				iss_rd   = 1'b0;
				iss_hit  = 1'b1;
				iss_last = (sweep_q == LAST_ADDR);
			end
			OP_PAINT: begin
				iss_addr = cell_addr;
				iss_wr   = cell_in && !brush_empty;
				iss_rd   = 1'b0;
				iss_hit  = cell_in && !brush_empty;
				iss_last = brush_empty || (j_last && k_last);
			end
			OP_READ: begin
				iss_addr = cell_addr;
				iss_wr   = 1'b0;
				iss_rd   = cell_in && !brush_empty;
				iss_hit  = cell_in && !brush_empty;
				iss_last = brush_empty || (j_last && k_last);
			end
			default: begin
				iss_addr = sweep_q;
				iss_wr   = 1'b0;
				iss_rd   = 1'b0;
				iss_hit  = 1'b0;
				iss_last = 1'b1;
			end
		endcase
	end

	always_comb begin
		old_px    = (fwd_v_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata_s1;
		new_px    = blend(old_px, cmd_q.color);
		mem_we    = (st_q == ST_CLR) || (v_s1 && wr_s1);
		mem_waddr = (st_q == ST_CLR) ? sweep_q : addr_s1;
		mem_wdata = (st_q == ST_CLR) ? 24'd0 : new_px;
		done_s1   = v_s1 && last_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= frame_mem[iss_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
		addr_s1    <= iss_addr;
		wr_s1      <= iss_wr;
		rd_s1      <= iss_rd;
		hit_s1     <= iss_hit;
		last_s1    <= iss_last;
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_px;
		if (done_s1) begin
			out_red_q   <= rd_s1 ? old_px[23:16] : 8'd0;
			out_green_q <= rd_s1 ? old_px[15:8] : 8'd0;
			out_blue_q  <= rd_s1 ? old_px[7:0] : 8'd0;
			out_hit_q   <= hit_acc_q | hit_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			j_q         <= '0;
			k_q         <= '0;
			sweep_q     <= '0;
			hit_acc_q   <= 1'b0;
			v_s1        <= 1'b0;
			fwd_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1    <= iss_v;
			fwd_v_q <= v_s1 && wr_s1;
			if (v_s1 && hit_s1) begin
				hit_acc_q <= 1'b1;
			end
			if (done_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						st_q    <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					if (pop) begin
						j_q       <= '0;
						k_q       <= '0;
						sweep_q   <= '0;
						hit_acc_q <= 1'b0;
						st_q      <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd_q.op == OP_CLEAR) begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end else if (k_last) begin
						k_q <= '0;
						j_q <= j_q + SIZE_W'(1);
					end else begin
						k_q <= k_q + SIZE_W'(1);
					end
					if (iss_last) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_wait_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WAIT) |-> (v_s1 && last_s1))
		else $error("final pixel missing from write stage");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && last_s1) |-> (!out_valid_q || !out_stall))
		else $error("result overwrites a pending transaction");
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLR) |-> (!v_s1 && !out_valid_q))
		else $error("pixel activity during frame clearing");
`endif

endmodule

`default_nettype wire

/* src/framebuffer_alpha_blit_engine_unit.sv */
// Alpha-blending blitter over an on-chip frame store.
// Input channel (in_valid / in_stall) takes one command per transaction: mode,
// position and source color. Output channel (out_valid / out_stall) returns one
// result per command, in order: the pixel read (zero unless a read inside the
// frame) and hit. Configuration writes (cfg_valid / cfg_ready, cfg_index,
// cfg_data) set offsets, picture size and brush thickness; cfg_ready is always
// high. The user must make writes only while the block is idle; the block
// itself does not enforce this. Commands land in a two-entry queue; the back
// end then runs one command at a time through a read-blend-write pipeline
// over a frame memory with one read and one write port, one pixel per cycle.
// A command steps through one cell for blit and read, t*t cells for a stamp
// of thickness t and every frame pixel for clear, then passes a wait state;
// out_valid rises once its last pixel has left the write stage.
// After reset the back end zeroes the frame, one pixel per cycle, over all
// FRAME_HEIGHT * FRAME_WIDTH pixels (65536 by default); in_stall is held high
// meanwhile. When the receiver stalls, the result stays in the output register,
// the back end holds before its next command and the queue keeps accepting
// until full.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_alpha_blit_engine_unit
	import fbab_pkg::*;
#(
	parameter int FRAME_HEIGHT = 256,
	parameter int FRAME_WIDTH  = 256,
	parameter int MAX_BRUSH    = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire  [1:0]            mode,
	input  wire  [10:0]           pos_line,
	input  wire  [10:0]           pos_column,
	input  wire  [7:0]            src_red,
	input  wire  [7:0]            src_green,
	input  wire  [7:0]            src_blue,
	input  wire  [7:0]            src_alpha,
	output logic                  out_valid,
	input  wire                   out_stall,
	output logic [7:0]            read_red,
	output logic [7:0]            read_green,
	output logic [7:0]            read_blue,
	output logic                  hit,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	logic clearing;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t q_head;

	fbab_front #(
		.MAX_BRUSH(MAX_BRUSH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.pos_line  (pos_line),
		.pos_column(pos_column),
		.src_red   (src_red),
		.src_green (src_green),
		.src_blue  (src_blue),
		.src_alpha (src_alpha),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	fbab_cmd_fifo u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head    (q_head),
		.empty   (q_empty)
	);

	fbab_back #(
		.FRAME_HEIGHT(FRAME_HEIGHT),
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_red  (read_red),
		.read_green(read_green),
		.read_blue (read_blue),
		.hit       (hit)
	);

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb
	import fbab_pkg::*;
();

	localparam int FH = 256;
	localparam int FW = 256;
	localparam int MAXB = 8;
	localparam int LIMIT = 4_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 160;
	localparam int PLAN_ROWS = 41;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       hit;
	} readout_t;

	typedef struct packed {
		bit       fixed;
		readout_t want;
	} pin_t;

	typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		mode_t                 m;
		int                    ln;
		int                    cl;
		color_t                c;
		bit                    fixed;
		readout_t              want;
	} plan_row_t;

	localparam readout_t MISS = '0;
	localparam readout_t HIT_ONLY = '{8'h00, 8'h00, 8'h00, 1'b1};

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	mode_t                 mode;
	logic [10:0]           pos_line;
	logic [10:0]           pos_column;
	logic [7:0]            src_red;
	logic [7:0]            src_green;
	logic [7:0]            src_blue;
	logic [7:0]            src_alpha;
	logic                  out_valid;
	logic                  out_stall;
	logic [7:0]            read_red;
	logic [7:0]            read_green;
	logic [7:0]            read_blue;
	logic                  hit;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit [23:0] frame_px [FH*FW];
	int off_line = 0;
	int off_col = 0;
	int pic_h = 0;
	int pic_w = 0;
	int brush = 1;
	readout_t due_readouts[$];
	pin_t pins[$];
	int errors = 0;
	int cycle_count = 0;
	bit calm_in = 0;
	plan_row_t plan [PLAN_ROWS];

	framebuffer_alpha_blit_engine_unit #(
		.FRAME_HEIGHT(FH),
		.FRAME_WIDTH(FW),
		.MAX_BRUSH(MAXB)
	) i_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] mix_chan(int old_c, int src_c, int a);
		return 8'((old_c * a + src_c * (255 - a) + 127) / 255);
	endfunction

	function automatic bit paint_px(int row, int col, color_t c);
		int i;
		bit [23:0] px;
		if (row < 0 || row >= FH || col < 0 || col >= FW)
			return 0;
		i = row * FW + col;
		px = frame_px[i];
		frame_px[i] = {mix_chan(px[23:16], c.red, c.alpha), mix_chan(px[15:8], c.green, c.alpha),
			mix_chan(px[7:0], c.blue, c.alpha)};
		return 1;
	endfunction

	function automatic readout_t apply_command(mode_t m, int ln, int cl, color_t c);
		readout_t r;
		int t;
		int h;
		int i;
		int j;
		int k;
		r = '0;
		case (m)
		MODE_CLEAR: begin
			for (i = 0; i < FH * FW; i++)
				void'(paint_px(i / FW, i % FW, c));
			r.hit = 1;
		end
		MODE_BLIT: begin
			if (ln < pic_h && cl < pic_w)
				r.hit = paint_px(ln + off_line, cl + off_col, c);
		end
		MODE_STAMP: begin
			t = (brush > MAXB) ? MAXB : brush;
			h = t / 2;
			for (j = -h; j < t - h; j++)
				for (k = -h; k < t - h; k++)
					if (paint_px(off_line + ln + j, off_col + cl + k, c))
						r.hit = 1;
		end
		default: begin
			if (ln < FH && cl < FW) begin
				r.red = frame_px[ln * FW + cl][23:16];
				r.green = frame_px[ln * FW + cl][15:8];
				r.blue = frame_px[ln * FW + cl][7:0];
				r.hit = 1;
			end
		end
		endcase
		return r;
	endfunction

	function automatic void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
		REG_OFFSET_LINE: off_line = int'($signed(val));
		REG_OFFSET_COLUMN: off_col = int'($signed(val));
		REG_PICTURE_HEIGHT: pic_h = int'(val);
		REG_PICTURE_WIDTH: pic_w = int'(val);
		REG_BRUSH_THICKNESS: brush = int'(val[3:0]);
		default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		color_t c;
		readout_t r;
		pin_t p;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				set_register(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				c = {src_red, src_green, src_blue, src_alpha};
				r = apply_command(mode, int'(pos_line), int'(pos_column), c);
				if (pins.size() != 0) begin
					p = pins.pop_front();
					if (p.fixed)
						r = p.want;
				end
				due_readouts.insert(due_readouts.size(), r);
			end
		end
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		readout_t owed;
		if (arst_n && out_valid && !out_stall) begin
			if (due_readouts.size() == 0) begin
				$error("result transaction with no expectation waiting");
				errors++;
			end else begin
				owed = due_readouts.pop_front();
				check_field("read_red", owed.red, read_red);
				check_field("read_green", owed.green, read_green);
				check_field("read_blue", owed.blue, read_blue);
				check_field("hit", {7'd0, owed.hit}, {7'd0, hit});
			end
		end
	end

	initial begin
		int run;
		int stall;
		out_stall = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			run = ($urandom_range(0, 99) < 10) ? $urandom_range(100, 400) : $urandom_range(1, 8);
			out_stall <= 0;
			repeat (run) @(posedge clk);
			stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			out_stall <= 1;
			repeat (stall) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_offset();
		case ($urandom_range(0, 9))
		0: return 12'h800;
		1: return 12'h7FF;
		2, 3: return 12'd0;
		4, 5, 6: return 12'($urandom_range(0, 16) - 8);
		default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_size();
		case ($urandom_range(0, 7))
		0: return 12'd0;
		1: return 12'd2048;
		2: return 12'hFFF;
		3: return 12'd256;
		default: return 12'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_brush();
		int t;
		case ($urandom_range(0, 9))
		0: t = 0;
		1: t = $urandom_range(9, 15);
		2: t = 8;
		default: t = $urandom_range(1, 8);
		endcase
		return {8'($urandom), 4'(t)};
	endfunction

	function automatic int aim(int off, int lim);
		int p;
		case ($urandom_range(0, 6))
		0: p = $urandom_range(0, 2047);
		1, 2: begin
			if (lim > 0)
				p = $urandom_range(0, ((lim > 2048) ? 2048 : lim) - 1);
			else
				p = -1;
		end
		default: p = int'($urandom_range(0, 263)) - 4 - off;
		endcase
		if (p < 0 || p > 2047)
			p = $urandom_range(0, 2047);
		return p;
	endfunction

	function automatic plan_row_t put(mode_t m, int ln, int cl, color_t c);
		plan_row_t row;
		row = '{ROW_CMD, '0, '0, m, ln, cl, c, 1'b0, MISS};
		return row;
	endfunction

	function automatic plan_row_t pin(mode_t m, int ln, int cl, color_t c, readout_t want);
		plan_row_t row;
		row = '{ROW_CMD, '0, '0, m, ln, cl, c, 1'b1, want};
		return row;
	endfunction

	function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row = '{ROW_CFG, idx, val, MODE_CLEAR, 0, 0, '0, 1'b0, MISS};
		return row;
	endfunction

	task automatic send_cmd(mode_t m, int ln, int cl, color_t c);
		int gap;
		in_valid <= 1;
		mode <= m;
		pos_line <= 11'(ln);
		pos_column <= 11'(cl);
		src_red <= c.red;
		src_green <= c.green;
		src_blue <= c.blue;
		src_alpha <= c.alpha;
		do @(posedge clk); while (in_stall);
		gap = calm_in ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		in_valid <= 0;
		do @(posedge clk); while (due_readouts.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int ph;
		int k;
		int r;
		int ln;
		int cl;
		int gl;
		int gc;
		int gh;
		int gw;
		int last_ln;
		int last_cl;
		mode_t m;
		color_t c;
		logic [CFG_DATA_W-1:0] v;

		arst_n = 0;
		in_valid = 0;
		mode = MODE_CLEAR;
		pos_line = '0;
		pos_column = '0;
		src_red = '0;
		src_green = '0;
		src_blue = '0;
		src_alpha = '0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		last_ln = 0;
		last_cl = 0;

		plan = '{
			pin(MODE_READ, 0, 0, '0, HIT_ONLY),
			pin(MODE_READ, 255, 255, '0, HIT_ONLY),
			pin(MODE_READ, 256, 0, '0, MISS),
			pin(MODE_READ, 2047, 2047, '0, MISS),
			pin(MODE_BLIT, 0, 0, 32'hFFFFFF00, MISS),
			reg_row(REG_PICTURE_HEIGHT, 12'd256),
			reg_row(REG_PICTURE_WIDTH, 12'd256),
			pin(MODE_BLIT, 0, 0, 32'hFF800100, HIT_ONLY),
			pin(MODE_READ, 0, 0, '0, '{8'hFF, 8'h80, 8'h01, 1'b1}),
			pin(MODE_BLIT, 0, 0, 32'h000000FF, HIT_ONLY),
			put(MODE_BLIT, 0, 0, 32'h00FF8080),
			put(MODE_READ, 0, 0, '0),
			pin(MODE_BLIT, 255, 255, 32'h12345600, HIT_ONLY),
			pin(MODE_BLIT, 256, 0, 32'hFFFFFF00, MISS),
			reg_row(REG_OFFSET_LINE, 12'h800),
			reg_row(REG_OFFSET_COLUMN, 12'h7FF),
			reg_row(REG_PICTURE_HEIGHT, 12'hFFF),
			reg_row(REG_PICTURE_WIDTH, 12'hFFF),
			pin(MODE_BLIT, 2047, 0, 32'hAA55AA7F, MISS),
			reg_row(REG_OFFSET_LINE, 12'hFFF),
			reg_row(REG_OFFSET_COLUMN, 12'h800),
			pin(MODE_BLIT, 1, 2047, 32'h55AA5501, MISS),
			pin(MODE_STAMP, 0, 2047, 32'h01020300, MISS),
			reg_row(REG_OFFSET_LINE, 12'h000),
			reg_row(REG_OFFSET_COLUMN, 12'h000),
			reg_row(REG_BRUSH_THICKNESS, 12'h000),
			pin(MODE_STAMP, 10, 10, 32'hFFFFFF00, MISS),
			reg_row(REG_BRUSH_THICKNESS, 12'h00F),
			pin(MODE_STAMP, 0, 0, 32'hC0C0C000, HIT_ONLY),
			pin(MODE_READ, 3, 3, '0, '{8'hC0, 8'hC0, 8'hC0, 1'b1}),
			reg_row(REG_BRUSH_THICKNESS, 12'hFF3),
			put(MODE_STAMP, 255, 255, 32'h01020340),
			put(MODE_READ, 255, 254, '0),
			reg_row(REG_SPARE_LO, 12'hFFF),
			reg_row(REG_SPARE_HI, 12'h000),
			pin(MODE_STAMP, 2047, 2047, 32'hFFFFFF00, MISS),
			pin(MODE_CLEAR, 0, 0, 32'h20406000, HIT_ONLY),
			pin(MODE_READ, 100, 100, '0, '{8'h20, 8'h40, 8'h60, 1'b1}),
			pin(MODE_CLEAR, 2047, 2047, 32'hFFFFFFFF, HIT_ONLY),
			put(MODE_CLEAR, 0, 0, 32'hFF00FF80),
			put(MODE_READ, 0, 0, '0)
		};

		repeat (8) @(posedge clk);
		arst_n <= 1;

		foreach (plan[n]) begin
			if (plan[n].kind == ROW_CFG) begin
				if (!cfg_valid)
					settle();
				write_reg(plan[n].idx, plan[n].val);
			end else begin
				cfg_valid <= 0;
				pins.insert(pins.size(), pin_t'{plan[n].fixed, plan[n].want});
				send_cmd(plan[n].m, plan[n].ln, plan[n].cl, plan[n].c);
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			v = pick_offset();
			write_reg(REG_OFFSET_LINE, v);
			gl = int'($signed(v));
			v = pick_offset();
			write_reg(REG_OFFSET_COLUMN, v);
			gc = int'($signed(v));
			v = pick_size();
			write_reg(REG_PICTURE_HEIGHT, v);
			gh = int'(v);
			v = pick_size();
			write_reg(REG_PICTURE_WIDTH, v);
			gw = int'(v);
			write_reg(REG_BRUSH_THICKNESS, pick_brush());
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 12'($urandom));
			cfg_valid <= 0;
			calm_in = ($urandom_range(0, 3) == 0);

			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if ((ph == 2 || ph == 5) && k == 0)
					m = MODE_CLEAR;
				else if (r < 40)
					m = MODE_BLIT;
				else if (r < 65)
					m = MODE_STAMP;
				else
					m = MODE_READ;

				c.red = 8'($urandom);
				c.green = 8'($urandom);
				c.blue = 8'($urandom);
				case ($urandom_range(0, 9))
				0: c.alpha = 8'd0;
				1: c.alpha = 8'd255;
				default: c.alpha = 8'($urandom);
				endcase

				case (m)
				MODE_BLIT: begin
					ln = aim(gl, gh);
					cl = aim(gc, gw);
					last_ln = ln + gl;
					last_cl = cl + gc;
				end
				MODE_STAMP: begin
					ln = aim(gl, 0);
					cl = aim(gc, 0);
					last_ln = ln + gl;
					last_cl = cl + gc;
				end
				MODE_READ: begin
					ln = last_ln;
					cl = last_cl + int'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1) == 0 || ln < 0 || ln > 2047 || cl < 0 || cl > 2047)
					begin
						ln = aim(0, 0);
						cl = aim(0, 0);
					end
				end
				default: begin
					ln = $urandom_range(0, 2047);
					cl = $urandom_range(0, 2047);
				end
				endcase

				send_cmd(m, ln, cl, c);
			end
		end

		settle();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
